### src/union_find_earliest_full_connect_core_macros.svh
// Assertion macros for the connectivity core.
`ifndef UNION_FIND_EARLIEST_FULL_CONNECT_CORE_MACROS_SVH
`define UNION_FIND_EARLIEST_FULL_CONNECT_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ufc_pkg.sv
`timescale 1ns / 1ps
package ufc_pkg;

  // Fixed field widths
  localparam int ID_W    = 10;
  localparam int COUNT_W = 11;
  localparam int TS_W    = 32;

  // Register reset value
  localparam int NODE_COUNT_RESET = 1024;

  // Operation codes carried in s_tuser
  localparam logic OP_CONNECT = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Input tdata layout: timestamp, node_a, node_b, zero pad
  localparam int S_TS_LSB    = 0;
  localparam int S_A_LSB     = S_TS_LSB + TS_W;
  localparam int S_B_LSB     = S_A_LSB + ID_W;
  localparam int S_TDATA_W   = 56;

  // Output tdata layout: component_count, found, hit_now, earliest_time, zero pad
  localparam int M_COUNT_LSB = 0;
  localparam int M_FOUND_BIT = M_COUNT_LSB + COUNT_W;
  localparam int M_HIT_BIT   = M_FOUND_BIT + 1;
  localparam int M_TIME_LSB  = M_HIT_BIT + 1;
  localparam int M_USED_W    = M_TIME_LSB + TS_W;
  localparam int M_TDATA_W   = 48;

  typedef struct packed {
    logic               skipped;
    logic [COUNT_W-1:0] component_count;
    logic               found;
    logic               hit_now;
    logic [TS_W-1:0]    earliest_time;
  } result_t;

endpackage

### src/ufc_forest_mem.sv
`timescale 1ns / 1ps
module ufc_forest_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 21
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/ufc_out_stage.sv
`timescale 1ns / 1ps
module ufc_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  ufc_pkg::result_t                 load_data,
  output logic                             free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // component_count, found, hit_now, earliest_time, zero pad
  output logic [ufc_pkg::M_TDATA_W-1:0]    m_tdata,
  // skipped
  output logic [0:0]                       m_tuser
);
  import ufc_pkg::*;

  result_t held;

  // Slot can take a new item when empty or draining this cycle
  assign free = !m_tvalid || m_tready;

  // Hold valid until the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  // Pack fields, lowest first
  assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, held.earliest_time, held.hit_now,
                    held.found, held.component_count};
  assign m_tuser = held.skipped;

endmodule

### src/union_find_earliest_full_connect_core.sv
`timescale 1ns / 1ps
// Sequence: a merging connect walks both ids to their roots, then makes the link and grow
// writes before its result; a connect whose ids share a root skips both writes, a skipped
// connect goes straight to the result, and a clear item runs the clearing pass.
// Flow: one item at a time; the next item is accepted in the cycle after the result loads.
// Reset: synchronous active-high rst, then a clearing pass over MAX_NODES ids, s_tready low.
module union_find_earliest_full_connect_core #(
  parameter int MAX_NODES  = 1024,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ufc_pkg::COUNT_W-1:0]         cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // timestamp, node_a, node_b, zero pad
  input  logic [ufc_pkg::S_TDATA_W-1:0]       s_tdata,
  // operation
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // component_count, found, hit_now, earliest_time, zero pad
  output logic [ufc_pkg::M_TDATA_W-1:0]       m_tdata,
  // skipped
  output logic [0:0]                          m_tuser
);
  import ufc_pkg::*;

  localparam int AW     = $clog2(MAX_NODES);
  localparam int SW     = $clog2(MAX_NODES + 1);
  localparam int WORD_W = AW + SW;
  localparam int TW     = (TIME_WIDTH < TS_W) ? TIME_WIDTH : TS_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
  localparam logic [COUNT_W-1:0] RESET_ACTIVE =
    COUNT_W'((NODE_COUNT_RESET > MAX_NODES) ? MAX_NODES : NODE_COUNT_RESET);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK_A = 7'b0000100,
    S_WALK_B = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_GROW   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t              state;
  logic [AW-1:0]       sweep_addr;
  logic                clear_reply;
  logic                item_clear;
  logic                skip;
  logic [TW-1:0]       ts;
  logic [AW-1:0]       node_b;
  logic [AW-1:0]       cur;
  logic [AW-1:0]       ra;
  logic [AW-1:0]       rb;
  logic [SW-1:0]       sa;
  logic [SW-1:0]       sb;
  logic [COUNT_W-1:0]  components;
  logic                found_flag;
  logic [TW-1:0]       first_time;
  logic [COUNT_W-1:0]  node_count;

  logic [COUNT_W-1:0]  active;
  logic                accept;
  logic                in_op;
  logic [ID_W-1:0]     in_a;
  logic [ID_W-1:0]     in_b;
  logic                in_skip;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [WORD_W-1:0]   mem_rdata;
  logic [AW-1:0]       rd_parent;
  logic [SW-1:0]       rd_size;
  logic                at_root;
  logic                a_small;
  logic [AW-1:0]       link_small;
  logic [AW-1:0]       link_big;
  logic [SW:0]         size_sum;
  logic                out_free;
  logic                out_load;
  logic                hit;
  result_t             result;

  // Active node count is the register limited to the forest size
  assign active = (32'(node_count) > MAX_NODES) ? COUNT_W'(MAX_NODES) : node_count;

  // Input handshake and field unpack
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tuser[0];
  assign in_a     = s_tdata[S_A_LSB +: ID_W];
  assign in_b     = s_tdata[S_B_LSB +: ID_W];
  assign in_skip  = ({1'b0, in_a} >= active) || ({1'b0, in_b} >= active);

  // Forest entry: parent above size
  assign rd_parent = mem_rdata[SW +: AW];
  assign rd_size   = mem_rdata[SW-1:0];
  assign at_root   = (rd_parent == cur);

  // Smaller tree goes under the larger one; ties hang b's root under a's
  assign a_small    = (sa < sb);
  assign link_small = a_small ? ra : rb;
  assign link_big   = a_small ? rb : ra;
  assign size_sum   = {1'b0, sa} + {1'b0, sb};

  // Pick the read address for the next walk step
  always_comb begin
    mem_raddr = cur;
    priority case (1'b1)
      accept:            mem_raddr = AW'(in_a);
      state == S_WALK_A: mem_raddr = at_root ? node_b : rd_parent;
      state == S_WALK_B: mem_raddr = rd_parent;
      default:           mem_raddr = cur;
    endcase
  end

  // Drive the write port: clearing pass or the two union writes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = {sweep_addr, SW'(1)};
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = link_small;
        mem_wdata = {link_big, a_small ? sa : sb};
      end
      S_GROW: begin
        mem_we    = 1'b1;
        mem_waddr = link_big;
        mem_wdata = {link_big, size_sum[SW-1:0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ufc_forest_mem #(
    .ADDR_W(AW),
    .DATA_W(WORD_W)
  ) u_forest (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Form the result; the first count of one latches the time
  assign out_load = (state == S_FINISH) && out_free;
  assign hit      = !skip && !item_clear && (components == COUNT_W'(1)) && !found_flag;

  always_comb begin
    result.skipped         = skip;
    result.component_count = components;
    result.found           = found_flag || hit;
    result.hit_now         = hit;
    result.earliest_time   = found_flag ? TS_W'(first_time) : (hit ? TS_W'(ts) : '0);
  end

  ufc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .load_data(result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_W'(NODE_COUNT_RESET);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // Sequencer: clear pass, two root walks, union writes, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      sweep_addr  <= '0;
      clear_reply <= 1'b0;
      item_clear  <= 1'b0;
      skip        <= 1'b0;
      components  <= RESET_ACTIVE;
      found_flag  <= 1'b0;
      first_time  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sweep_addr == LAST_ADDR) begin
            state <= clear_reply ? S_FINISH : S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            ts         <= s_tdata[S_TS_LSB +: TW];
            node_b     <= AW'(in_b);
            cur        <= AW'(in_a);
            item_clear <= (in_op == OP_CLEAR);
            if (in_op == OP_CLEAR) begin
              state       <= S_CLEAR;
              sweep_addr  <= '0;
              clear_reply <= 1'b1;
              skip        <= 1'b0;
              components  <= active;
              found_flag  <= 1'b0;
              first_time  <= '0;
            end else begin
              skip  <= in_skip;
              state <= in_skip ? S_FINISH : S_WALK_A;
            end
          end
        end
        S_WALK_A: begin
          if (at_root) begin
            ra    <= cur;
            sa    <= rd_size;
            cur   <= node_b;
            state <= S_WALK_B;
          end else begin
            cur <= rd_parent;
          end
        end
        S_WALK_B: begin
          if (at_root) begin
            rb    <= cur;
            sb    <= rd_size;
            state <= (cur == ra) ? S_FINISH : S_LINK;
          end else begin
            cur <= rd_parent;
          end
        end
        S_LINK: begin
          state <= S_GROW;
        end
        S_GROW: begin
          if (components != '0) begin
            components <= components - COUNT_W'(1);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (hit) begin
              found_flag <= 1'b1;
              first_time <= ts;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "union_find_earliest_full_connect_core_macros.svh"

  // The found flag drops only on an accepted clear item
  `UFC_ASSERT_NOW(a_found_falls_on_clear, clk, rst,
                  $fell(found_flag) && !$past(rst),
                  $past(accept && (in_op == OP_CLEAR)),
                  "found flag cleared without a clear item")

  // The count changes only by a merge or a clear
  `UFC_ASSERT_NOW(a_count_source, clk, rst,
                  (components != $past(components)) && !$past(rst),
                  ($past(state) == S_GROW) || $past(accept && (in_op == OP_CLEAR)),
                  "component count changed outside merge or clear")

  // One item at a time: no accept right after an accept
  `UFC_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready,
                   "input ready again in the cycle after an accept")

  // A first-hit result always reports found
  `UFC_ASSERT_NOW(a_hit_implies_found, clk, rst, m_tvalid && m_tdata[M_HIT_BIT],
                  m_tdata[M_FOUND_BIT], "hit_now set without found")

endmodule

### tb/union_find_earliest_full_connect_core_tb.sv
`timescale 1ns / 1ps
module union_find_earliest_full_connect_core_tb;
  import ufc_pkg::*;

  localparam int MAX_NODES  = 1024;
  localparam int TIME_WIDTH = 32;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;

  union_find_earliest_full_connect_core #(
    .MAX_NODES  (MAX_NODES),
    .TIME_WIDTH (TIME_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Shadow forest and search state
  logic [ID_W-1:0]    shadow_parent [MAX_NODES];
  logic [COUNT_W-1:0] shadow_size   [MAX_NODES];
  logic [COUNT_W-1:0] shadow_components;
  logic               shadow_found;
  logic [TS_W-1:0]    shadow_first_time;
  logic [COUNT_W-1:0] node_limit;

  result_t pending_results [$];
  int      fail_count = 0;
  int      mismatch_count = 0;
  bit      idle_en = 1'b1;
  bit      hold_req = 1'b0;

  function automatic int unsigned active_nodes();
    return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
  endfunction

  function automatic void reinit_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      shadow_parent[i] = ID_W'(i);
      shadow_size[i]   = COUNT_W'(1);
    end
    shadow_components = COUNT_W'(active_nodes());
    shadow_found      = 1'b0;
    shadow_first_time = '0;
  endfunction

  function automatic logic [ID_W-1:0] root_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] node;
    node = id;
    while (shadow_parent[node] != node) node = shadow_parent[node];
    return node;
  endfunction

  // Apply one item to the shadow forest and return the result it should give
  function automatic result_t predict_connectivity(input logic op, input logic [TS_W-1:0] ts,
                                                   input logic [ID_W-1:0] a,
                                                   input logic [ID_W-1:0] b);
    result_t         res;
    logic [ID_W-1:0] ra, rb;
    int unsigned     lim;
    res = '0;
    lim = active_nodes();
    if (op == OP_CLEAR) begin
      reinit_forest();
    end else if (a >= lim || b >= lim) begin
      res.skipped = 1'b1;
    end else begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        if (shadow_size[ra] < shadow_size[rb]) begin
          shadow_parent[ra] = rb;
          shadow_size[rb]   = shadow_size[rb] + shadow_size[ra];
        end else begin
          shadow_parent[rb] = ra;
          shadow_size[ra]   = shadow_size[ra] + shadow_size[rb];
        end
        if (shadow_components > 0) shadow_components = shadow_components - 1'b1;
      end
      if (shadow_components == 1 && !shadow_found) begin
        shadow_found      = 1'b1;
        shadow_first_time = ts;
        res.hit_now       = 1'b1;
      end
    end
    res.component_count = shadow_components;
    res.found           = shadow_found;
    res.earliest_time   = shadow_found ? shadow_first_time : '0;
    return res;
  endfunction

  // Offer one item after a random gap; called and returns at a falling edge
  task automatic send_item(input logic op, input logic [TS_W-1:0] ts,
                           input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
    int unsigned          gap, r;
    logic [S_TDATA_W-1:0] word;
    gap = 0;
    if (idle_en) begin
      r = $urandom_range(0, 99);
      if (r >= 95)      gap = $urandom_range(20, 60);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[S_TS_LSB +: TS_W] = ts;
    word[S_A_LSB +: ID_W]  = a;
    word[S_B_LSB +: ID_W]  = b;
    s_tdata  <= word;
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pending_results.push_back(predict_connectivity(op, ts, a, b));
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_node_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    node_limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned     r, lim;
    logic [TS_W-1:0] ts;
    logic [ID_W-1:0] a, b;
    lim = active_nodes();
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       ts = '0;
      1:       ts = '1;
      default: ts = $urandom;
    endcase
    if (r < 3) begin
      send_item(OP_CLEAR, ts, ID_W'($urandom), ID_W'($urandom));
    end else if (r < 13) begin
      // Noise: ids anywhere, sometimes exactly at the limit
      a = ID_W'($urandom);
      b = (r < 8) ? ID_W'(lim) : ID_W'($urandom);
      if (r[0]) send_item(OP_CONNECT, ts, a, b);
      else      send_item(OP_CONNECT, ts, b, a);
    end else begin
      a = ID_W'($urandom_range(0, lim - 1));
      b = ID_W'($urandom_range(0, lim - 1));
      send_item(OP_CONNECT, ts, a, b);
    end
  endtask

  // Full size after reset: extreme ids and timestamps, repeat of a union
  task automatic test_default_size();
    send_item(OP_CONNECT, '0, ID_W'(0), ID_W'(1023));
    send_item(OP_CONNECT, '1, ID_W'(1023), ID_W'(0));
    send_item(OP_CONNECT, 32'd5, ID_W'(512), ID_W'(511));
  endtask

  // One node: a self connect is a full connect, other ids are unknown
  task automatic test_single_node();
    set_node_count(COUNT_W'(1));
    send_item(OP_CLEAR, 32'd9, ID_W'(0), ID_W'(0));
    send_item(OP_CONNECT, '1, ID_W'(0), ID_W'(0));
    send_item(OP_CONNECT, 32'd3, ID_W'(0), ID_W'(1));
    send_item(OP_CONNECT, 32'd4, ID_W'(1023), ID_W'(0));
    send_item(OP_CONNECT, 32'd7, ID_W'(0), ID_W'(0));
  endtask

  // Small forest joined up, then cleared to start a new search
  task automatic test_full_connect();
    set_node_count(COUNT_W'(4));
    send_item(OP_CLEAR, '0, ID_W'(0), ID_W'(0));
    send_item(OP_CONNECT, 32'd10, ID_W'(0), ID_W'(1));
    send_item(OP_CONNECT, 32'd20, ID_W'(2), ID_W'(3));
    send_item(OP_CONNECT, 32'hdead_beef, ID_W'(1), ID_W'(3));
    send_item(OP_CONNECT, 32'd40, ID_W'(0), ID_W'(2));
    send_item(OP_CLEAR, 32'd50, ID_W'(0), ID_W'(0));
    send_item(OP_CONNECT, 32'd60, ID_W'(3), ID_W'(0));
  endtask

  // Grow the node count without a clear so the count runs down to zero
  task automatic test_count_saturation();
    set_node_count(COUNT_W'(3));
    send_item(OP_CLEAR, '0, ID_W'(0), ID_W'(0));
    set_node_count(COUNT_W'(8));
    send_item(OP_CONNECT, 32'd1, ID_W'(0), ID_W'(1));
    send_item(OP_CONNECT, 32'd2, ID_W'(2), ID_W'(3));
    send_item(OP_CONNECT, 32'd3, ID_W'(4), ID_W'(5));
    send_item(OP_CONNECT, 32'd4, ID_W'(6), ID_W'(7));
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_output_hold();
    set_node_count(COUNT_W'(16));
    idle_en  = 1'b1;
    hold_req = 1'b1;
    repeat (12) send_random_item();
    drain();
  endtask

  task automatic test_random_phases();
    logic [COUNT_W-1:0] count;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0)      count = COUNT_W'(1024);
      else if (phase == 1) count = COUNT_W'(2);
      else if ($urandom_range(0, 9) < 7) count = COUNT_W'($urandom_range(2, 32));
      else                 count = COUNT_W'($urandom_range(33, 1024));
      set_node_count(count);
      idle_en = (phase % 3) != 2;
      // Most phases start from a fresh forest, one keeps the old one
      if (phase != 5) send_item(OP_CLEAR, $urandom, ID_W'(0), ID_W'(0));
      repeat (50) send_random_item();
      if (phase == 3) drain();
    end
    idle_en = 1'b1;
  endtask

  // Output side: random ready with short and long stalls, and the long hold
  initial begin
    int unsigned r;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (!idle_en) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.skipped         = m_tuser[0];
      got.component_count = m_tdata[M_COUNT_LSB +: COUNT_W];
      got.found           = m_tdata[M_FOUND_BIT];
      got.hit_now         = m_tdata[M_HIT_BIT];
      got.earliest_time   = m_tdata[M_TIME_LSB +: TS_W];
      if (pending_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none expected: skip=%0b count=%0d found=%0b hit=%0b time=%h",
                   $realtime, got.skipped, got.component_count, got.found, got.hit_now,
                   got.earliest_time);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp skip=%0b count=%0d found=%0b hit=%0b time=%h / got skip=%0b count=%0d found=%0b hit=%0b time=%h",
                     $realtime, want.skipped, want.component_count, want.found, want.hit_now,
                     want.earliest_time, got.skipped, got.component_count, got.found,
                     got.hit_now, got.earliest_time);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    node_limit = COUNT_W'(NODE_COUNT_RESET);
    reinit_forest();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_size();
    test_single_node();
    test_full_connect();
    test_count_saturation();
    test_output_hold();
    test_random_phases();
    drain();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### union_find_earliest_full_connect_core.f
+incdir+src
src/ufc_pkg.sv
src/ufc_forest_mem.sv
src/ufc_out_stage.sv
src/union_find_earliest_full_connect_core.sv
tb/union_find_earliest_full_connect_core_tb.sv
